// ----- hw/rtl/crpi_pkg.sv -----
// crpi_pkg: shared constants, codes and stage payload types for the
// catmull-rom path interpolator; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package crpi_pkg;

  // store size and fixed-point format
  localparam int MAX_POINTS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int ONE_FX     = 1 << FRAC_BITS;

  // field widths
  localparam int VAL_W   = 32;
  localparam int PIDX_W  = 4;
  localparam int POS_W   = FRAC_BITS + 1;
  localparam int CNT_W   = 5;
  localparam int CFG_W   = CNT_W;
  localparam int CFGI_W  = 1;

  // internal widths
  localparam int AW    = $clog2(MAX_POINTS);
  localparam int NW    = $clog2(MAX_POINTS + 1);
  localparam int U_W   = FRAC_BITS + 1;
  localparam int US_W  = U_W + 1;
  localparam int K_W   = VAL_W + 4;
  localparam int P1_W  = K_W + US_W;
  localparam int S1_W  = K_W + 2;
  localparam int P2_W  = S1_W + US_W;
  localparam int S2_W  = S1_W + 1;
  localparam int P3_W  = S2_W + US_W;
  localparam int LIN_W = VAL_W + 3;
  localparam int R_W   = VAL_W + 8;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_EVAL = 1'b1
  } func_e;

  typedef enum logic {
    MODE_LINEAR = 1'b0,
    MODE_SPLINE = 1'b1
  } mode_e;

  typedef enum logic [CFGI_W-1:0] {
    REG_POINT_COUNT = 1'b0,
    REG_PATH_MODE   = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    mode_e            mode;
  } cfg_t;

  // front stage to point store
  typedef struct packed {
    func_e                   func;
    mode_e                   mode;
    logic [U_W-1:0]          u;
    logic [AW-1:0]           ia;
    logic [AW-1:0]           ib;
    logic [AW-1:0]           ic;
    logic [AW-1:0]           id;
    logic                    ld_ok;
    logic [AW-1:0]           ld_addr;
    logic signed [VAL_W-1:0] ld_value;
  } fetch_t;

  // point store to arithmetic pipe
  typedef struct packed {
    mode_e                   mode;
    logic [U_W-1:0]          u;
    logic signed [VAL_W-1:0] pa;
    logic signed [VAL_W-1:0] pb;
    logic signed [VAL_W-1:0] pc;
    logic signed [VAL_W-1:0] pd;
  } pts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/crpi_front.sv -----
// crpi_front: input register stage; clamps count and position, finds the
// segment, local position and the four point addresses; uses crpi_pkg
`timescale 1ns / 1ps
`default_nettype none

module crpi_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  crpi_pkg::cfg_t                  cfg,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_func,
  input  logic [crpi_pkg::PIDX_W-1:0]     in_point_index,
  input  logic signed [crpi_pkg::VAL_W-1:0] in_point_value,
  input  logic [crpi_pkg::POS_W-1:0]      in_position,
  output logic                            dn_valid,
  input  logic                            dn_ready,
  output crpi_pkg::fetch_t                dn_data
);
  import crpi_pkg::*;

  localparam int SC_W = POS_W + NW;

  logic               v1_r;
  fetch_t             st_r;
  fetch_t             st_nxt;

  logic [NW-1:0]      n;
  logic [POS_W-1:0]   t;
  logic [SC_W-1:0]    scaled;
  logic [NW:0]        seg_raw;
  logic [NW-1:0]      nm2;
  logic [NW-1:0]      seg;
  logic [NW:0]        sp2;
  logic [NW:0]        nm1;

  always_comb begin
    if (cfg.count < CNT_W'(2)) begin
      n = NW'(2);
    end else if (int'(cfg.count) > MAX_POINTS) begin
      n = NW'(MAX_POINTS);
    end else begin
      n = NW'(cfg.count);
    end
  end

  always_comb begin
    t = (int'(in_position) > ONE_FX) ? POS_W'(ONE_FX) : in_position;
    scaled  = SC_W'(t) * SC_W'(n - NW'(1));
    seg_raw = scaled[SC_W-1:FRAC_BITS];
    nm2     = n - NW'(2);
    // the end of the path lands on the last segment with u at one
    seg     = (seg_raw > (NW+1)'(nm2)) ? nm2 : NW'(seg_raw);
    sp2     = (NW+1)'(seg) + (NW+1)'(2);
    nm1     = (NW+1)'(n) - (NW+1)'(1);
  end

  always_comb begin
    st_nxt.func     = func_e'(in_func);
    st_nxt.mode     = cfg.mode;
    st_nxt.u        = U_W'(scaled - (SC_W'(seg) << FRAC_BITS));
    st_nxt.ib       = AW'(seg);
    st_nxt.ic       = AW'(seg + NW'(1));
    st_nxt.ia       = (seg == '0) ? '0 : AW'(seg - NW'(1));
    // neighbour past the end repeats the last point
    st_nxt.id       = (sp2 > nm1) ? AW'(nm1) : AW'(sp2);
    st_nxt.ld_ok    = int'(in_point_index) < MAX_POINTS;
    st_nxt.ld_addr  = AW'(in_point_index);
    st_nxt.ld_value = in_point_value;
  end

  assign in_ready = !v1_r || dn_ready;
  assign dn_valid = v1_r;
  assign dn_data  = st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_ready) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      st_r <= st_nxt;
    end
  end

  a_addr_order: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && st_r.func == FUNC_EVAL) |->
      (st_r.ic == st_r.ib + 1'b1) && (st_r.ia <= st_r.ib) && (st_r.id >= st_r.ic))
    else $error("segment addresses out of order");

endmodule

`default_nettype wire

// ----- hw/rtl/crpi_store.sv -----
// crpi_store: control point store, two copies with two read ports each,
// written by load beats and read by evaluate beats; uses crpi_pkg
`timescale 1ns / 1ps
`default_nettype none

module crpi_store (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  crpi_pkg::fetch_t up_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output crpi_pkg::pts_t   dn_data
);
  import crpi_pkg::*;

  logic [VAL_W-1:0] mem_ab [MAX_POINTS];
  logic [VAL_W-1:0] mem_cd [MAX_POINTS];

  logic        v2_r;
  pts_t        pts_r;
  logic        up_fire;
  logic        is_load;
  logic        wr_en;
  logic        rd_en;

  assign up_ready = !v2_r || dn_ready;
  assign up_fire  = up_valid && up_ready;
  assign is_load  = up_data.func == FUNC_LOAD;
  assign wr_en    = up_fire && is_load && up_data.ld_ok;
  assign rd_en    = up_fire && !is_load;

  // loads write as they leave this stage, so later reads see them
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_ab[up_data.ld_addr] <= up_data.ld_value;
      mem_cd[up_data.ld_addr] <= up_data.ld_value;
    end
    if (rd_en) begin
      pts_r.pa   <= $signed(mem_ab[up_data.ia]);
      pts_r.pb   <= $signed(mem_ab[up_data.ib]);
      pts_r.pc   <= $signed(mem_cd[up_data.ic]);
      pts_r.pd   <= $signed(mem_cd[up_data.id]);
      pts_r.mode <= up_data.mode;
      pts_r.u    <= up_data.u;
    end
  end

  // load beats end here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (up_ready) begin
      v2_r <= up_valid && !is_load;
    end
  end

  assign dn_valid = v2_r;
  assign dn_data  = pts_r;

  a_load_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (up_fire && is_load) |=> !v2_r)
    else $error("load beat passed the point store");

endmodule

`default_nettype wire

// ----- hw/rtl/crpi_arith.sv -----
// crpi_arith: seven-stage arithmetic pipe, spline coefficients, three
// multiply and round steps, linear blend and saturation; uses crpi_pkg
`timescale 1ns / 1ps
`default_nettype none

module crpi_arith (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  crpi_pkg::pts_t                    up_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [crpi_pkg::VAL_W-1:0] out_value,
  output logic                              out_saturated
);
  import crpi_pkg::*;

  localparam int NST = 7;

  logic [NST-1:0] v_r;
  logic [NST-1:0] rdy;

  // stage 0: coefficients
  logic signed [K_W-1:0]   ax, bx, cx, dx;
  logic signed [K_W-1:0]   k1_nxt, k2_nxt, k3_nxt, diff_nxt;
  logic signed [K_W-1:0]   k1_s0_r, k2_s0_r, k3_s0_r, diff_s0_r;
  logic signed [VAL_W-1:0] b_s0_r;
  logic [U_W-1:0]          u_s0_r;
  mode_e                   mode_s0_r;

  // stage 1: first product
  logic signed [K_W-1:0]   mop;
  logic signed [P1_W-1:0]  prod1_nxt;
  logic signed [P1_W-1:0]  prod1_s1_r;
  logic signed [K_W-1:0]   k1_s1_r, k2_s1_r;
  logic signed [VAL_W-1:0] b_s1_r;
  logic [U_W-1:0]          u_s1_r;
  mode_e                   mode_s1_r;

  // stage 2: s1 and linear result
  logic signed [P1_W-1:0]  rnd1;
  logic signed [P1_W-1:0]  sh1;
  logic signed [S1_W-1:0]  s1_nxt;
  logic signed [LIN_W-1:0] lin_nxt;
  logic signed [S1_W-1:0]  s1_s2_r;
  logic signed [LIN_W-1:0] lin_s2_r;
  logic signed [K_W-1:0]   k1_s2_r;
  logic signed [VAL_W-1:0] b_s2_r;
  logic [U_W-1:0]          u_s2_r;
  mode_e                   mode_s2_r;

  // stage 3: second product
  logic signed [P2_W-1:0]  prod2_nxt;
  logic signed [P2_W-1:0]  prod2_s3_r;
  logic signed [LIN_W-1:0] lin_s3_r;
  logic signed [K_W-1:0]   k1_s3_r;
  logic signed [VAL_W-1:0] b_s3_r;
  logic [U_W-1:0]          u_s3_r;
  mode_e                   mode_s3_r;

  // stage 4: s2
  logic signed [P2_W-1:0]  rnd2;
  logic signed [P2_W-1:0]  sh2;
  logic signed [S2_W-1:0]  s2_nxt;
  logic signed [S2_W-1:0]  s2_s4_r;
  logic signed [LIN_W-1:0] lin_s4_r;
  logic signed [VAL_W-1:0] b_s4_r;
  logic [U_W-1:0]          u_s4_r;
  mode_e                   mode_s4_r;

  // stage 5: third product
  logic signed [P3_W-1:0]  prod3_nxt;
  logic signed [P3_W-1:0]  prod3_s5_r;
  logic signed [LIN_W-1:0] lin_s5_r;
  logic signed [VAL_W-1:0] b_s5_r;
  mode_e                   mode_s5_r;

  // stage 6: final round and saturation
  logic signed [P3_W-1:0]  rnd3;
  logic signed [P3_W-1:0]  sh3;
  logic signed [R_W-1:0]   r;
  logic signed [VAL_W-1:0] value_nxt;
  logic                    sat_nxt;
  logic signed [VAL_W-1:0] value_s6_r;
  logic                    sat_s6_r;

  // bubbles collapse: a stage moves when it is empty or the next one moves
  always_comb begin
    rdy[NST-1] = !v_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= up_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign up_ready = rdy[0];

  // stage 0
  always_comb begin
    ax       = K_W'(up_data.pa);
    bx       = K_W'(up_data.pb);
    cx       = K_W'(up_data.pc);
    dx       = K_W'(up_data.pd);
    k1_nxt   = cx - ax;
    k2_nxt   = (ax <<< 1) - ((bx <<< 2) + bx) + (cx <<< 2) - dx;
    k3_nxt   = ((bx <<< 1) + bx) - ((cx <<< 1) + cx) + dx - ax;
    diff_nxt = cx - bx;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      k1_s0_r   <= k1_nxt;
      k2_s0_r   <= k2_nxt;
      k3_s0_r   <= k3_nxt;
      diff_s0_r <= diff_nxt;
      b_s0_r    <= up_data.pb;
      u_s0_r    <= up_data.u;
      mode_s0_r <= up_data.mode;
    end
  end

  // stage 1, the multiplier is shared by both modes
  always_comb begin
    mop       = (mode_s0_r == MODE_SPLINE) ? k3_s0_r : diff_s0_r;
    prod1_nxt = mop * $signed({1'b0, u_s0_r});
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      prod1_s1_r <= prod1_nxt;
      k1_s1_r    <= k1_s0_r;
      k2_s1_r    <= k2_s0_r;
      b_s1_r     <= b_s0_r;
      u_s1_r     <= u_s0_r;
      mode_s1_r  <= mode_s0_r;
    end
  end

  // stage 2, round to nearest with ties upward
  always_comb begin
    rnd1    = prod1_s1_r + $signed(P1_W'(1) << (FRAC_BITS - 1));
    sh1     = rnd1 >>> FRAC_BITS;
    s1_nxt  = S1_W'(k2_s1_r) + S1_W'(sh1);
    lin_nxt = LIN_W'(b_s1_r) + LIN_W'(sh1);
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s1_s2_r   <= s1_nxt;
      lin_s2_r  <= lin_nxt;
      k1_s2_r   <= k1_s1_r;
      b_s2_r    <= b_s1_r;
      u_s2_r    <= u_s1_r;
      mode_s2_r <= mode_s1_r;
    end
  end

  // stage 3
  assign prod2_nxt = s1_s2_r * $signed({1'b0, u_s2_r});

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      prod2_s3_r <= prod2_nxt;
      lin_s3_r   <= lin_s2_r;
      k1_s3_r    <= k1_s2_r;
      b_s3_r     <= b_s2_r;
      u_s3_r     <= u_s2_r;
      mode_s3_r  <= mode_s2_r;
    end
  end

  // stage 4
  always_comb begin
    rnd2   = prod2_s3_r + $signed(P2_W'(1) << (FRAC_BITS - 1));
    sh2    = rnd2 >>> FRAC_BITS;
    s2_nxt = S2_W'(k1_s3_r) + S2_W'(sh2);
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s2_s4_r   <= s2_nxt;
      lin_s4_r  <= lin_s3_r;
      b_s4_r    <= b_s3_r;
      u_s4_r    <= u_s3_r;
      mode_s4_r <= mode_s3_r;
    end
  end

  // stage 5
  assign prod3_nxt = s2_s4_r * $signed({1'b0, u_s4_r});

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      prod3_s5_r <= prod3_nxt;
      lin_s5_r   <= lin_s4_r;
      b_s5_r     <= b_s4_r;
      mode_s5_r  <= mode_s4_r;
    end
  end

  // stage 6, doubled polynomial so the last shift is one bit longer
  always_comb begin
    rnd3 = prod3_s5_r + $signed(P3_W'(1) << FRAC_BITS);
    sh3  = rnd3 >>> (FRAC_BITS + 1);
    if (mode_s5_r == MODE_SPLINE) begin
      r = R_W'(b_s5_r) + R_W'(sh3);
    end else begin
      r = R_W'(lin_s5_r);
    end
    // out of range when the bits above the sign are not all copies of it
    sat_nxt = !((&r[R_W-1:VAL_W-1]) || !(|r[R_W-1:VAL_W-1]));
    if (!sat_nxt) begin
      value_nxt = r[VAL_W-1:0];
    end else if (r[R_W-1]) begin
      value_nxt = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      value_nxt = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      value_s6_r <= value_nxt;
      sat_s6_r   <= sat_nxt;
    end
  end

  assign out_valid     = v_r[NST-1];
  assign out_value     = value_s6_r;
  assign out_saturated = sat_s6_r;

  a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !rdy[0] |-> (&v_r))
    else $error("pipe refused a beat while holding a bubble");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |->
      (out_value == {1'b1, {(VAL_W-1){1'b0}}}) ||
      (out_value == {1'b0, {(VAL_W-1){1'b1}}}))
    else $error("saturated result not at a range limit");

endmodule

`default_nettype wire

// ----- hw/rtl/catmull_rom_path_interpolator_unit.sv -----
// catmull_rom_path_interpolator_unit: top level, configuration registers
// and the front, point store and arithmetic stages; uses crpi_pkg
//
//   channel  | ports                                          | direction
//   ---------+------------------------------------------------+----------
//   input    | in_valid/in_ready, func, index, value, position | in
//   result   | out_valid/out_ready, out_value, out_saturated  | out
//   config   | cfg_we, cfg_index, cfg_wdata                   | in
//
// one beat enters per cycle while in_ready is high; an evaluate beat passes
// the front register, the store read register and the 7 arithmetic stages
// in turn; a load beat is written to the store and leaves a bubble there.
// rst_n clears the stage valid bits and sets point_count 2, Catmull-Rom mode;
// the point store is not cleared. a stall on out_ready backs up stage by
// stage, and in_ready drops only once every stage holds a beat.
`timescale 1ns / 1ps
`default_nettype none

module catmull_rom_path_interpolator_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [crpi_pkg::CFGI_W-1:0]         cfg_index,
  input  logic [crpi_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_func,
  input  logic [crpi_pkg::PIDX_W-1:0]         in_point_index,
  input  logic signed [crpi_pkg::VAL_W-1:0]   in_point_value,
  input  logic [crpi_pkg::POS_W-1:0]          in_position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [crpi_pkg::VAL_W-1:0]   out_value,
  output logic                                out_saturated
);
  import crpi_pkg::*;

  logic [CNT_W-1:0] count_r;
  mode_e            mode_r;
  cfg_t             cfg;

  logic   f_valid;
  logic   f_ready;
  fetch_t f_data;
  logic   p_valid;
  logic   p_ready;
  pts_t   p_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_W'(2);
      mode_r  <= MODE_SPLINE;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_POINT_COUNT: count_r <= cfg_wdata[CNT_W-1:0];
        REG_PATH_MODE:   mode_r  <= mode_e'(cfg_wdata[0]);
        default:         count_r <= count_r;
      endcase
    end
  end

  assign cfg.count = count_r;
  assign cfg.mode  = mode_r;

  crpi_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_point_index (in_point_index),
    .in_point_value (in_point_value),
    .in_position    (in_position),
    .dn_valid       (f_valid),
    .dn_ready       (f_ready),
    .dn_data        (f_data)
  );

  crpi_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_data  (f_data),
    .dn_valid (p_valid),
    .dn_ready (p_ready),
    .dn_data  (p_data)
  );

  crpi_arith u_arith (
    .clk           (clk),
    .rst_n         (rst_n),
    .up_valid      (p_valid),
    .up_ready      (p_ready),
    .up_data       (p_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value),
    .out_saturated (out_saturated)
  );

endmodule

`default_nettype wire
